// File: rtl/dchs_pkg.sv
// Shared types, constants and tables for the disk image CHS geometry block.
package dchs_pkg;

  // Field widths
  localparam int unsigned BytesW = 32;
  localparam int unsigned TotalW = 23;  // image_bytes / 512
  localparam int unsigned ProdW  = 12;  // heads * sectors_per_track, at most 4080
  localparam int unsigned QuotW  = 16;  // cylinder count
  localparam int unsigned HeadW  = 5;
  localparam int unsigned SptW   = 8;
  localparam int unsigned SelW   = 2;
  localparam int unsigned CmpW   = ProdW + 16;

  // Sector size shift, head range and size threshold for the small limit
  localparam int unsigned        SectorShift = 9;
  localparam logic [HeadW-1:0]   HeadFirst   = 5'd4;
  localparam logic [HeadW-1:0]   HeadLast    = 5'd16;
  localparam logic [BytesW-1:0]  SmallImage  = 32'd536870912;
  localparam logic [SelW-1:0]    SelLast     = 2'd2;

  // Cylinder limit plus one is a power of two: 1024 or 65536
  localparam int unsigned SmallCylShift = 10;
  localparam int unsigned LargeCylShift = 16;

  // Sectors per track choices, tried in order
  function automatic logic [SptW-1:0] spt_of(input logic [SelW-1:0] sel);
    logic [SptW-1:0] spt;
    case (sel)
      2'd0:    spt = 8'd63;
      2'd1:    spt = 8'd127;
      2'd2:    spt = 8'd255;
      default: spt = 8'd255;
    endcase
    return spt;
  endfunction

  // Item travelling down the divider row
  typedef struct packed {
    logic              present;
    logic [ProdW-1:0]  rem;      // partial remainder
    logic [QuotW-1:0]  dvd;      // dividend bits left, quotient bits shifted in
    logic [ProdW-1:0]  divisor;
    logic [HeadW-1:0]  heads;
    logic [SptW-1:0]   spt;
  } div_item_t;

  typedef struct packed {
    logic      valid;
    div_item_t data;
  } div_slot_t;

endpackage

// File: rtl/dchs_if.sv
// Valid/ready channel interfaces for the geometry block input and result items.
interface dchs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] image_bytes;

  modport source (output valid, output image_bytes, input ready);
  modport sink   (input valid, input image_bytes, output ready);
endinterface

interface dchs_out_if;
  logic        valid;
  logic        ready;
  logic        present;
  logic [15:0] cylinders;
  logic [4:0]  heads;
  logic [7:0]  sectors_per_track;

  modport source (output valid, output present, output cylinders, output heads,
                  output sectors_per_track, input ready);
  modport sink   (input valid, input present, input cylinders, input heads,
                  input sectors_per_track, output ready);
endinterface

// File: rtl/dchs_search.sv
// Candidate search: walks sectors/heads pairs one per cycle, then launches the divide.
module dchs_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dchs_pkg::BytesW-1:0]   image_bytes_i,
  input  logic                          out_free_i,
  output dchs_pkg::div_slot_t           launch_o
);

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StLaunch
  } state_e;

  state_e                         state_q;
  logic [dchs_pkg::TotalW-1:0]    total_q;
  logic                           large_q;
  logic                           present_q;
  logic [dchs_pkg::SelW-1:0]      sel_q;
  logic [dchs_pkg::HeadW-1:0]     head_q;
  logic [dchs_pkg::ProdW-1:0]     prod_q;

  logic [dchs_pkg::CmpW-1:0]      total_ext;
  logic [dchs_pkg::CmpW-1:0]      bound;
  logic                           fits;
  logic                           last_cand;
  logic [dchs_pkg::SptW-1:0]      spt_cur;
  logic [dchs_pkg::SptW-1:0]      spt_next;
  logic [dchs_pkg::SelW-1:0]      sel_next;

  // Fit test: cylinders <= limit  <=>  total < prod * (limit + 1)
  assign total_ext = dchs_pkg::CmpW'(total_q);
  assign bound     = large_q ? (dchs_pkg::CmpW'(prod_q) << dchs_pkg::LargeCylShift)
                             : (dchs_pkg::CmpW'(prod_q) << dchs_pkg::SmallCylShift);
  assign fits      = total_ext < bound;
  assign last_cand = (sel_q == dchs_pkg::SelLast) && (head_q == dchs_pkg::HeadLast);
  assign spt_cur   = dchs_pkg::spt_of(sel_q);
  assign sel_next  = sel_q + 2'd1;
  assign spt_next  = dchs_pkg::spt_of(sel_next);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StSearch;
          end
        end
        StSearch: begin
          if (fits || last_cand) begin
            state_q <= StLaunch;
          end
        end
        StLaunch: begin
          if (out_free_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Candidate registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      total_q   <= image_bytes_i[dchs_pkg::BytesW-1:dchs_pkg::SectorShift];
      large_q   <= image_bytes_i > dchs_pkg::SmallImage;
      present_q <= |image_bytes_i;
      sel_q     <= '0;
      head_q    <= dchs_pkg::HeadFirst;
      prod_q    <= dchs_pkg::ProdW'({dchs_pkg::spt_of('0), 2'b00});
    end else if (state_q == StSearch && !fits && !last_cand) begin
      if (head_q == dchs_pkg::HeadLast) begin
        sel_q  <= sel_next;
        head_q <= dchs_pkg::HeadFirst;
        prod_q <= dchs_pkg::ProdW'({spt_next, 2'b00});
      end else begin
        head_q <= head_q + 5'd1;
        prod_q <= prod_q + dchs_pkg::ProdW'(spt_cur);
      end
    end
  end

  // Seed the divider: high dividend bits already below the divisor
  always_comb begin
    launch_o.valid        = (state_q == StLaunch) && out_free_i;
    launch_o.data.present = present_q;
    launch_o.data.rem     = dchs_pkg::ProdW'(total_q[dchs_pkg::TotalW-1:dchs_pkg::QuotW]);
    launch_o.data.dvd     = total_q[dchs_pkg::QuotW-1:0];
    launch_o.data.divisor = prod_q;
    launch_o.data.heads   = head_q;
    launch_o.data.spt     = spt_cur;
  end

endmodule

// File: rtl/dchs_div_cell.sv
// One restoring-division cell: decides one quotient bit and hands the item on.
module dchs_div_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dchs_pkg::div_slot_t  slot_i,
  output dchs_pkg::div_slot_t  slot_o
);

  logic                         valid_q;
  dchs_pkg::div_item_t          data_q;
  dchs_pkg::div_item_t          data_d;
  logic [dchs_pkg::ProdW:0]     trial;
  logic                         qbit;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial  = {slot_i.data.rem, slot_i.data.dvd[dchs_pkg::QuotW-1]};
    qbit   = trial >= {1'b0, slot_i.data.divisor};
    data_d = slot_i.data;
    if (qbit) begin
      data_d.rem = dchs_pkg::ProdW'(trial - {1'b0, slot_i.data.divisor});
    end else begin
      data_d.rem = trial[dchs_pkg::ProdW-1:0];
    end
    data_d.dvd = {slot_i.data.dvd[dchs_pkg::QuotW-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= slot_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_i.valid) begin
      data_q <= data_d;
    end
  end

  assign slot_o.valid = valid_q;
  assign slot_o.data  = data_q;

endmodule

// File: rtl/disk_image_chs_geometry.sv
// The search tests one sectors/heads pair a cycle, trying 1 to 39 candidates, then a row
// of 16 divide cells yields one cylinder bit each. One item in flight: the next item is
// taken in the cycle its predecessor's result is first offered, and a result still held
// in the output register stalls the next launch into the divide row.
// Reset (asynchronous, active low) empties the search, the divide row and the output.
module disk_image_chs_geometry (
  input  logic              clk_i,
  input  logic              rst_ni,
  dchs_in_if.sink           in_i,
  dchs_out_if.source        out_o
);

  localparam int unsigned Cells = dchs_pkg::QuotW;

  dchs_pkg::div_slot_t  chain [Cells+1];
  logic                 inflight_q;
  logic                 out_valid_q;
  logic                 present_q;
  logic [15:0]          cyl_q;
  logic [4:0]           heads_q;
  logic [7:0]           spt_q;
  logic                 accept;
  logic                 done;

  assign accept      = in_i.valid && in_i.ready;
  assign done        = chain[Cells].valid;
  assign in_i.ready  = !inflight_q;

  // Search sequencer
  dchs_search u_search (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (accept),
    .image_bytes_i (in_i.image_bytes),
    .out_free_i    (!out_valid_q),
    .launch_o      (chain[0])
  );

  // Row of divide cells
  for (genvar g = 0; g < Cells; g++) begin : g_cell
    dchs_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .slot_i (chain[g]),
      .slot_o (chain[g+1])
    );
  end

  // Item in flight from accept until its result is registered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        inflight_q <= 1'b1;
      end else if (done) begin
        inflight_q <= 1'b0;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register; a zero size gives all-zero fields
  always_ff @(posedge clk_i) begin
    if (done) begin
      present_q <= chain[Cells].data.present;
      cyl_q     <= chain[Cells].data.present ? chain[Cells].data.dvd : '0;
      heads_q   <= chain[Cells].data.present ? chain[Cells].data.heads : '0;
      spt_q     <= chain[Cells].data.present ? chain[Cells].data.spt : '0;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.present           = present_q;
  assign out_o.cylinders         = cyl_q;
  assign out_o.heads             = heads_q;
  assign out_o.sectors_per_track = spt_q;

endmodule

// File: rtl/dchs_checker.sv
// Port-level checks for the geometry block, bound to the top level.
module dchs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        present_i,
  input logic [15:0] cylinders_i,
  input logic [4:0]  heads_i,
  input logic [7:0]  spt_i
);

  // A waiting result holds still
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cylinders_i)
      && $stable(heads_i) && $stable(spt_i) && $stable(present_i))
    else $error("result changed while stalled");

  // One item at a time: taking an item closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while busy");

  // Absent geometry is all zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !present_i |-> cylinders_i == 16'd0 && heads_i == 5'd0 && spt_i == 8'd0)
    else $error("nonzero fields with present low");

  // A present geometry uses a legal sectors/heads pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && present_i |-> (spt_i == 8'd63 || spt_i == 8'd127 || spt_i == 8'd255)
      && heads_i >= 5'd4 && heads_i <= 5'd16)
    else $error("illegal sectors or heads");

endmodule

bind disk_image_chs_geometry dchs_checker u_dchs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .present_i   (out_o.present),
  .cylinders_i (out_o.cylinders),
  .heads_i     (out_o.heads),
  .spt_i       (out_o.sectors_per_track)
);
